>>> sv/stbs_pkg.sv
`default_nettype none

package stbs_pkg;

    // Widths of the transaction fields.
    localparam int POS_W      = 10;
    localparam int IN_VALUE_W = 32;

    // Defaults of the top-level parameters.
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Command codes.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;     // store the transaction value into the table
        logic load;      // set up the search range and issue the first probe
        logic step;      // move a bound and issue the next probe
        logic out_load;  // capture the result into the output registers
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;      // match found or range empty
    } t_dp_status;

endpackage

`default_nettype wire

>>> sv/stbs_datapath.sv
`default_nettype none

module stbs_datapath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_status                        o_status,
    input  wire logic        [POS_W-1:0]      i_write_position,
    input  wire logic signed [IN_VALUE_W-1:0] i_value,
    input  wire logic        [POS_W-1:0]      i_low_bound,
    input  wire logic        [POS_W-1:0]      i_high_bound,
    output logic                              o_found,
    output logic             [POS_W-1:0]      o_position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = POS_W + 1;

    typedef logic [SW-1:0]          t_span;
    typedef logic [VALUE_WIDTH-1:0] t_word;

    // The upper bound is kept exclusive (high plus one), so an empty range
    // is simply low >= high_p1 and no negative value is ever needed.
    t_word              r_table [TABLE_DEPTH];
    t_word              r_rdata;
    t_word              r_key;
    t_span              r_lo;
    t_span              r_hip1;
    logic  [POS_W-1:0]  r_mid;
    logic               r_found;
    logic  [POS_W-1:0]  r_pos;

    t_word              wr_data;
    t_span              ld_lo;
    t_span              ld_hip1;
    logic  [POS_W-1:0]  hib_sat;
    t_span              n_lo;
    t_span              n_hip1;
    logic  [POS_W-1:0]  n_mid;
    logic  [POS_W-1:0]  rd_pos;
    logic               empty;
    logic               hit;
    logic               below;

    function automatic logic [POS_W-1:0] mid_of(input t_span lo, input t_span hip1);
        t_span span;
        t_span sum;
        span = hip1 - lo - t_span'(1);
        sum  = lo + (span >> 1);
        return sum[POS_W-1:0];
    endfunction

    assign wr_data = VALUE_WIDTH'($unsigned(i_value));

    always_comb begin
        if (32'(i_high_bound) >= 32'(TABLE_DEPTH)) begin
            hib_sat = POS_W'(TABLE_DEPTH - 1);
        end else begin
            hib_sat = i_high_bound;
        end
        ld_lo = {1'b0, i_low_bound};
        if (32'(i_low_bound) >= 32'(TABLE_DEPTH)) begin
            ld_hip1 = ld_lo;
        end else begin
            ld_hip1 = {1'b0, hib_sat} + t_span'(1);
        end
    end

    assign empty = r_lo >= r_hip1;
    assign hit   = r_rdata == r_key;
    assign below = $signed(r_rdata) < $signed(r_key);

    assign o_status.done = empty || hit;

    always_comb begin
        if (below) begin
            n_lo   = {1'b0, r_mid} + t_span'(1);
            n_hip1 = r_hip1;
        end else begin
            n_lo   = r_lo;
            n_hip1 = {1'b0, r_mid};
        end
        n_mid = mid_of(n_lo, n_hip1);
    end

    always_comb begin
        if (i_cmd.load) begin
            rd_pos = mid_of(ld_lo, ld_hip1);
        end else if (i_cmd.step) begin
            rd_pos = n_mid;
        end else begin
            rd_pos = r_mid;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (32'(i_write_position) < 32'(TABLE_DEPTH))) begin
            r_table[AW'(i_write_position)] <= wr_data;
        end
        r_rdata <= r_table[AW'(rd_pos)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= wr_data;
            r_lo   <= ld_lo;
            r_hip1 <= ld_hip1;
            r_mid  <= rd_pos;
        end else if (i_cmd.step) begin
            r_lo   <= n_lo;
            r_hip1 <= n_hip1;
            r_mid  <= n_mid;
        end
        if (i_cmd.out_load) begin
            r_found <= !empty && hit;
            r_pos   <= (!empty && hit) ? r_mid : '0;
        end
    end

    assign o_found    = r_found;
    assign o_position = r_pos;

    // A probe always lies inside the live range.
    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> ({1'b0, r_mid} >= r_lo) && ({1'b0, r_mid} < r_hip1))
        else $error("probe position outside the search range");

    // Every step strictly shrinks the range.
    a_range_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_hip1 - r_lo) < $past(r_hip1 - r_lo))
        else $error("search range did not shrink");

    // The saturated upper bound never passes the end of the table.
    a_hip1_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> 32'(r_hip1) <= 32'(TABLE_DEPTH) || r_hip1 == r_lo)
        else $error("upper bound beyond the table");

endmodule

`default_nettype wire

>>> sv/stbs_ctrl.sv
`default_nettype none

module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_command,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_accept;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.write    = in_accept && (i_command == CMD_WRITE);
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_command == CMD_SEARCH)) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (!i_status.done) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> out_free)
        else $error("result register overwritten before it was taken");

    // A captured result is presented and the block returns to idle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid && (r_state == S_IDLE))
        else $error("captured result not presented");

    // An unfinished search always advances.
    a_search_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) && !i_status.done |-> o_cmd.step && !o_cmd.out_load)
        else $error("search stalled before completion");

endmodule

`default_nettype wire

>>> sv/sorted_table_binary_search_top.sv
// Sorted-table binary search.
// Input channel (i_in_valid / o_in_ready): a write transaction (command 0) stores
// i_value at i_write_position and gives no result; a search transaction
// (command 1) looks for i_value between i_low_bound and i_high_bound inclusive.
// Output channel (o_out_valid / i_out_ready): one result per search, o_found
// and o_position (zero when not found).
// Writes may stream at one per cycle while the block is idle. A search
// does one probe per cycle, set by the single read port of the table memory,
// and makes at most log2(TABLE_DEPTH) + 1 probes (11 for 1024 entries). The
// block takes no new transaction while a search is in progress, and is ready
// again in the cycle the result appears.
// The result sits in an output register: a stalled receiver does not block
// writes or the start of the next search; that search waits at its end until
// the register is free.
// Reset clears the control state and the output valid; the table contents are
// undefined until written.
`default_nettype none

module sorted_table_binary_search_top
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_command,
    input  wire logic        [POS_W-1:0]      i_write_position,
    input  wire logic signed [IN_VALUE_W-1:0] i_value,
    input  wire logic        [POS_W-1:0]      i_low_bound,
    input  wire logic        [POS_W-1:0]      i_high_bound,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_found,
    output logic             [POS_W-1:0]      o_position
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_write_position (i_write_position),
        .i_value          (i_value),
        .i_low_bound      (i_low_bound),
        .i_high_bound     (i_high_bound),
        .o_found          (o_found),
        .o_position       (o_position)
    );

endmodule

`default_nettype wire

>>> bench/stbs_checker.sv
module stbs_checker
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic                         i_command,
    input  wire logic        [POS_W-1:0]      i_write_position,
    input  wire logic signed [IN_VALUE_W-1:0] i_value,
    input  wire logic        [POS_W-1:0]      i_low_bound,
    input  wire logic        [POS_W-1:0]      i_high_bound,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic                         i_found,
    input  wire logic        [POS_W-1:0]      i_position,
    output int                                o_mismatches,
    output int                                o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_search_result;

    logic signed [VALUE_WIDTH-1:0] entry_table [TABLE_DEPTH];
    t_search_result                awaited_results [$];
    int                            mismatch_count = 0;

    initial begin
        // Entries that were never written read as zero here; the stimulus never probes them.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            entry_table[i] = '0;
        end
    end

    function automatic t_search_result binary_search_lookup(
        logic signed [VALUE_WIDTH-1:0] key,
        logic        [POS_W-1:0]       lob,
        logic        [POS_W-1:0]       hib
    );
        t_search_result res;
        int lo;
        int hi;
        int mid;
        res.found    = 1'b0;
        res.position = '0;
        if (int'(lob) >= TABLE_DEPTH) begin
            return res;
        end
        lo = int'(lob);
        hi = (int'(hib) >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(hib);
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (entry_table[mid] == key) begin
                res.found    = 1'b1;
                res.position = POS_W'(mid);
                return res;
            end
            if (entry_table[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_search_result oldest;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no search outstanding: found %0d, position %0d",
                           i_found, i_position);
                    mismatch_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    if (i_found !== oldest.found) begin
                        $error("found: expected %0d, actual %0d", oldest.found, i_found);
                        mismatch_count++;
                    end
                    if (i_position !== oldest.position) begin
                        $error("position: expected %0d, actual %0d",
                               oldest.position, i_position);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_command == CMD_WRITE) begin
                    if (int'(i_write_position) < TABLE_DEPTH) begin
                        entry_table[i_write_position] = i_value[VALUE_WIDTH-1:0];
                    end
                end else begin
                    awaited_results.push_back(
                        binary_search_lookup(i_value[VALUE_WIDTH-1:0], i_low_bound,
                                             i_high_bound));
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= awaited_results.size();
    end

endmodule

>>> bench/tb_sorted_table_binary_search_top.sv
module tb_sorted_table_binary_search_top;

    import stbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = DEFAULT_TABLE_DEPTH;
    localparam int WIN     = 128;
    localparam int HI_BASE = DEPTH - WIN;
    localparam logic signed [IN_VALUE_W-1:0] VAL_MIN = {1'b1, {(IN_VALUE_W-1){1'b0}}};
    localparam logic signed [IN_VALUE_W-1:0] VAL_MAX = {1'b0, {(IN_VALUE_W-1){1'b1}}};

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_in_valid       = 1'b0;
    logic                         i_command        = CMD_WRITE;
    logic        [POS_W-1:0]      i_write_position = '0;
    logic signed [IN_VALUE_W-1:0] i_value          = '0;
    logic        [POS_W-1:0]      i_low_bound      = '0;
    logic        [POS_W-1:0]      i_high_bound     = '0;
    logic                         i_out_ready      = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic                         o_found;
    logic        [POS_W-1:0]      o_position;

    int mismatches;
    int searches_in_flight;

    // Sender and receiver idling; both are switched off for the last stretch of the run.
    logic send_gaps_on = 1'b1;
    logic recv_stall_on = 1'b1;

    // Copy of the table contents, kept only to pick keys and order-preserving write values.
    logic signed [IN_VALUE_W-1:0] table_image [DEPTH];

    sorted_table_binary_search_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_write_position (i_write_position),
        .i_value          (i_value),
        .i_low_bound      (i_low_bound),
        .i_high_bound     (i_high_bound),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_position       (o_position)
    );

    stbs_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_write_position (i_write_position),
        .i_value          (i_value),
        .i_low_bound      (i_low_bound),
        .i_high_bound     (i_high_bound),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_found          (o_found),
        .i_position       (o_position),
        .o_mismatches     (mismatches),
        .o_pending        (searches_in_flight)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: ready drops in bursts while stalling is enabled.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && recv_stall_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_item(logic cmd, logic [POS_W-1:0] wpos,
                             logic signed [IN_VALUE_W-1:0] val,
                             logic [POS_W-1:0] lob, logic [POS_W-1:0] hib);
        if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_write_position <= wpos;
        i_value          <= val;
        i_low_bound      <= lob;
        i_high_bound     <= hib;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic store_entry(int pos, logic signed [IN_VALUE_W-1:0] val);
        table_image[pos] = val;
        send_item(CMD_WRITE, POS_W'(pos), val, POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic find_key(logic signed [IN_VALUE_W-1:0] key, int lo, int hi);
        send_item(CMD_SEARCH, POS_W'($urandom), key, POS_W'(lo), POS_W'(hi));
    endtask

    initial begin
        int kind;
        int bsel;
        int lo;
        int hi;
        int pos;
        int ws;
        logic signed [IN_VALUE_W-1:0] key;
        logic signed [IN_VALUE_W-1:0] saved;
        longint floor_v;
        longint ceil_v;
        longint span;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill a window at each end of the table in ascending order. Every non-empty
        // search range stays inside one window, so every probe lands on a written entry.
        for (int j = 0; j < 2 * WIN; j++) begin
            pos = (j < WIN) ? j : HI_BASE + j - WIN;
            store_entry(pos, IN_VALUE_W'(longint'(pos) * 4194304 - 64'sd2147483648
                                         + longint'($urandom_range(0, 4194303))));
        end

        // Directed cases.
        store_entry(0, VAL_MIN);
        store_entry(DEPTH - 1, VAL_MAX);
        find_key(VAL_MIN, 0, WIN - 1);
        find_key(VAL_MAX, HI_BASE, DEPTH - 1);
        find_key(VAL_MIN, 0, 0);
        find_key(VAL_MAX, DEPTH - 1, DEPTH - 1);
        find_key(table_image[64], 64, 64);
        find_key(table_image[65], 64, 64);
        find_key(table_image[50] + 1, 0, WIN - 1);
        find_key(table_image[10], 10, 9);
        find_key(table_image[0], DEPTH - 1, 0);
        find_key(table_image[100], 0, 99);
        find_key(table_image[100], 101, WIN - 1);
        // Duplicate neighbors still keep the table in order.
        store_entry(41, table_image[40]);
        find_key(table_image[40], 0, WIN - 1);
        // A single out-of-order entry; the probe path decides what is reported.
        saved = table_image[30];
        store_entry(30, VAL_MAX);
        find_key(VAL_MAX, 0, WIN - 1);
        find_key(VAL_MAX, 20, 40);
        store_entry(30, saved);
        find_key(saved, 0, WIN - 1);
        find_key(32'sd0, 0, WIN - 1);
        find_key(-32'sd1, 0, WIN - 1);
        find_key(32'sd0, HI_BASE, DEPTH - 1);
        find_key(-32'sd1, HI_BASE, DEPTH - 1);

        for (int n = 0; n < 320; n++) begin
            if (n == 270) begin
                send_gaps_on  <= 1'b0;
                recv_stall_on <= 1'b0;
            end
            kind = $urandom_range(0, 99);
            bsel = $urandom_range(0, 9);
            ws   = ($urandom_range(0, 1) == 0) ? 0 : HI_BASE;
            if (bsel == 0) begin
                lo = ws;
                hi = ws + WIN - 1;
            end else if (bsel == 1) begin
                lo = $urandom_range(1, DEPTH - 1);
                hi = $urandom_range(0, lo - 1);
            end else if (bsel == 2) begin
                lo = ws + $urandom_range(0, WIN - 1);
                hi = lo;
            end else begin
                lo = ws + $urandom_range(0, WIN - 1);
                hi = $urandom_range(lo, ws + WIN - 1);
            end
            pos = (lo <= hi) ? $urandom_range(lo, hi) : ws + $urandom_range(0, WIN - 1);
            if (kind < 40) begin
                find_key(table_image[pos], lo, hi);
            end else if (kind < 55) begin
                key = table_image[pos] + (($urandom_range(0, 1) == 0) ? 1 : -1);
                find_key(key, lo, hi);
            end else if (kind < 65) begin
                find_key($urandom, lo, hi);
            end else if (kind < 92) begin
                // Order-preserving write where the neighbors are in order: the new value lies between them.
                pos = ws + $urandom_range(0, WIN - 1);
                floor_v = (pos == ws) ? longint'(VAL_MIN) : longint'(table_image[pos - 1]);
                ceil_v  = (pos == ws + WIN - 1) ? longint'(VAL_MAX)
                                                : longint'(table_image[pos + 1]);
                if (floor_v <= ceil_v) begin
                    span = ceil_v - floor_v + 1;
                    store_entry(pos, IN_VALUE_W'(floor_v + longint'($urandom) % span));
                end else begin
                    store_entry(pos, $urandom);
                end
            end else begin
                store_entry(ws + $urandom_range(0, WIN - 1), $urandom);
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (searches_in_flight != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/stbs_pkg.sv
sv/stbs_datapath.sv
sv/stbs_ctrl.sv
sv/sorted_table_binary_search_top.sv
bench/stbs_checker.sv
bench/tb_sorted_table_binary_search_top.sv
